/* design/tss_pkg.sv */
// tss_pkg: shared types and constants of the tdma slot scheduler
// no dependencies; imported by tss_table and the top level
package tss_pkg;

  // widths of the slot index and of the aging limit (twice the 16-bit period)
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned LIMIT_W = 17;

  // period trimming
  localparam logic [15:0] PERIOD_MIN = 16'd5;
  localparam logic [15:0] PERIOD_MAX = 16'd1000;
  localparam logic [15:0] PERIOD_RESET = 16'd100;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_RX    = 2'd1,
    OP_START = 2'd2
  } op_e;

  typedef enum logic {
    CFG_MY_ADDR     = 1'b0,
    CFG_INIT_PERIOD = 1'b1
  } cfg_e;

  typedef enum logic [2:0] {
    T_IDLE,
    T_AGE_RD,
    T_AGE_EV,
    T_SHF_RD,
    T_SHF_WR,
    T_INS
  } tbl_state_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TBL,
    S_DIV,
    S_PUT
  } top_state_e;

  typedef struct packed {
    logic               start;
    logic               update;
    logic [31:0]        now;
    logic [31:0]        who;
    logic [31:0]        my_addr;
    logic [LIMIT_W-1:0] limit;
  } tss_tbl_req_t;

  typedef struct packed {
    logic              done;
    logic              dropped;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       prev_seen;
  } tss_tbl_rsp_t;

endpackage

/* design/tss_ifs.sv */
// tss_ifs: valid/ready channels for input items and result items
// no dependencies
interface tss_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] now_ms;
  logic [31:0] source_address;

  modport source (output valid, operation, now_ms, source_address, input ready);
  modport sink (input valid, operation, now_ms, source_address, output ready);
endinterface

interface tss_out_if;
  logic        valid;
  logic        ready;
  logic        transmit;
  logic [3:0]  my_slot;
  logic [4:0]  peer_count;
  logic [3:0]  peer_distance;
  logic [15:0] slot_period;
  logic [31:0] next_transmit_time;
  logic        sender_dropped;

  modport source (output valid, transmit, my_slot, peer_count, peer_distance, slot_period,
                  next_transmit_time, sender_dropped, input ready);
  modport sink (input valid, transmit, my_slot, peer_count, peer_distance, slot_period,
                next_transmit_time, sender_dropped, output ready);
endinterface

/* design/tss_div.sv */
// tss_div: restoring divider, one quotient bit per cycle
// depends on nothing but its parameters
module tss_div #(
  parameter int unsigned NW = 17,
  parameter int unsigned DW = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] quotient_o
);
  localparam int unsigned CNTW = $clog2(NW + 1);

  logic            busy_q, busy_d, done_q, done_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [DW-1:0]   rem_q, rem_d, dvs_q, dvs_d;
  logic [NW-1:0]   quo_q, quo_d;
  logic [DW:0]     trial;
  logic            fits;

  always_comb begin
    trial  = {rem_q, quo_q[NW-1]};
    fits   = trial >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNTW'(NW);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? DW'(trial - {1'b0, dvs_q}) : trial[DW-1:0];
      quo_d = {quo_q[NW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule

/* design/tss_table.sv */
// tss_table: sorted peer table in one synchronous ram with its sequencer
// depends on tss_pkg; ages, refreshes or inserts a peer, finds the own slot
module tss_table import tss_pkg::*; #(
  parameter int unsigned MAX_PEERS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tss_tbl_req_t                   req_i,
  output tss_tbl_rsp_t                   rsp_o,
  output logic [$clog2(MAX_PEERS+1)-1:0] live_o,
  output logic [$clog2(MAX_PEERS)-1:0]   own_o
);
  localparam int unsigned IW = $clog2(MAX_PEERS);
  localparam int unsigned CW = $clog2(MAX_PEERS + 1);

  logic [63:0] mem [MAX_PEERS];
  logic [63:0] rd_data_q;

  tbl_state_e state_q, state_d;
  logic [CW-1:0]      i_q, i_d, k_q, k_d, pos_q, pos_d, live_q, live_d;
  logic               pos_hit_q, pos_hit_d, found_q, found_d, ownf_q, ownf_d;
  logic [IW-1:0]      fidx_q, fidx_d, ownj_q, ownj_d, own_q, own_d;
  logic [31:0]        prev_q, prev_d, now_q, now_d, who_q, who_d, my_q, my_d;
  logic [LIMIT_W-1:0] lim_q, lim_d;
  logic               done_q, done_d, drop_q, drop_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;

  logic          rd_en, we;
  logic [IW-1:0] rd_addr, wa;
  logic [63:0]   wd;
  logic [31:0]   ent_addr, ent_seen;
  logic [CW-1:0] im1, pos_sel;
  logic          keep;

  assign ent_addr = rd_data_q[63:32];
  assign ent_seen = rd_data_q[31:0];
  assign im1      = i_q - 1'b1;
  assign pos_sel  = pos_hit_q ? pos_q : k_q;
  assign keep     = (now_q - ent_seen) <= 32'(lim_q);

  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    k_d       = k_q;
    pos_d     = pos_q;
    pos_hit_d = pos_hit_q;
    found_d   = found_q;
    fidx_d    = fidx_q;
    ownf_d    = ownf_q;
    ownj_d    = ownj_q;
    own_d     = own_q;
    live_d    = live_q;
    prev_d    = prev_q;
    now_d     = now_q;
    who_d     = who_q;
    my_d      = my_q;
    lim_d     = lim_q;
    done_d    = 1'b0;
    drop_d    = drop_q;
    slot_d    = slot_q;
    rd_en     = 1'b0;
    rd_addr   = i_q[IW-1:0];
    we        = 1'b0;
    wa        = k_q[IW-1:0];
    wd        = rd_data_q;
    case (state_q)
      T_IDLE: begin
        if (req_i.start) begin
          we     = 1'b1;
          wa     = '0;
          wd     = {req_i.my_addr, req_i.now};
          live_d = CW'(1);
          own_d  = '0;
          slot_d = '0;
          drop_d = 1'b0;
          prev_d = req_i.now;
          done_d = 1'b1;
        end else if (req_i.update) begin
          now_d     = req_i.now;
          who_d     = req_i.who;
          my_d      = req_i.my_addr;
          lim_d     = req_i.limit;
          i_d       = '0;
          k_d       = '0;
          found_d   = 1'b0;
          pos_hit_d = 1'b0;
          ownf_d    = 1'b0;
          state_d   = T_AGE_RD;
        end
      end
      T_AGE_RD: begin
        if (i_q == live_q) begin
          // aging pass over: decide refresh, drop or insert
          if (found_q) begin
            live_d  = k_q;
            slot_d  = SLOT_W'(fidx_q);
            own_d   = ownf_q ? ownj_q : own_q;
            drop_d  = 1'b0;
            done_d  = 1'b1;
            state_d = T_IDLE;
          end else if (k_q == CW'(MAX_PEERS)) begin
            live_d  = k_q;
            drop_d  = 1'b1;
            done_d  = 1'b1;
            state_d = T_IDLE;
          end else begin
            pos_d = pos_sel;
            if (pos_sel < k_q) begin
              i_d     = k_q;
              state_d = T_SHF_RD;
            end else begin
              state_d = T_INS;
            end
          end
        end else begin
          rd_en   = 1'b1;
          state_d = T_AGE_EV;
        end
      end
      T_AGE_EV: begin
        if (keep) begin
          we = 1'b1;
          wd = {ent_addr, (ent_addr == who_q) ? now_q : ent_seen};
          if (ent_addr == who_q) begin
            found_d = 1'b1;
            fidx_d  = k_q[IW-1:0];
            prev_d  = ent_seen;
          end
          if (!pos_hit_q && ent_addr > who_q) begin
            pos_hit_d = 1'b1;
            pos_d     = k_q;
          end
          if (ent_addr == my_q) begin
            ownf_d = 1'b1;
            ownj_d = k_q[IW-1:0];
          end
          k_d = k_q + 1'b1;
        end
        i_d     = i_q + 1'b1;
        state_d = T_AGE_RD;
      end
      T_SHF_RD: begin
        rd_en   = 1'b1;
        rd_addr = im1[IW-1:0];
        state_d = T_SHF_WR;
      end
      T_SHF_WR: begin
        we      = 1'b1;
        wa      = i_q[IW-1:0];
        i_d     = im1;
        state_d = (im1 == pos_q) ? T_INS : T_SHF_RD;
      end
      T_INS: begin
        we     = 1'b1;
        wa     = pos_q[IW-1:0];
        wd     = {who_q, now_q};
        live_d = k_q + 1'b1;
        slot_d = SLOT_W'(pos_q);
        prev_d = now_q;
        drop_d = 1'b0;
        if (who_q == my_q) begin
          own_d = pos_q[IW-1:0];
        end else if (ownf_q) begin
          own_d = (pos_q <= CW'(ownj_q)) ? ownj_q + 1'b1 : ownj_q;
        end
        done_d  = 1'b1;
        state_d = T_IDLE;
      end
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      live_q  <= '0;
      own_q   <= '0;
      done_q  <= 1'b0;
      i_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      live_q  <= live_d;
      own_q   <= own_d;
      done_q  <= done_d;
      i_q     <= i_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    pos_hit_q <= pos_hit_d;
    found_q   <= found_d;
    fidx_q    <= fidx_d;
    ownf_q    <= ownf_d;
    ownj_q    <= ownj_d;
    prev_q    <= prev_d;
    now_q     <= now_d;
    who_q     <= who_d;
    my_q      <= my_d;
    lim_q     <= lim_d;
    drop_q    <= drop_d;
    slot_q    <= slot_d;
  end

  // peer ram, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.dropped   = drop_q;
  assign rsp_o.slot      = slot_q;
  assign rsp_o.prev_seen = prev_q;
  assign live_o          = live_q;
  assign own_o           = own_q;
endmodule

/* design/tdma_slot_scheduler.sv */
// tdma_slot_scheduler: top level of the self-organizing tdma slot scheduler
// depends on tss_pkg, tss_ifs, tss_table and tss_div
//
// usage
//   in_ch carries items: operation (tick, packet received, start), now_ms and
//   source_address. out_ch returns exactly one result item per input item.
//   cfg_we_i/cfg_idx_i/cfg_data_i write my_address (index 0) and
//   initial_period (index 1); write only while the block is idle.
// sequencing
//   one item at a time. an item that leaves the table alone (idle tick,
//   ignored opcode, not yet started) goes straight to the output register;
//   start writes the own entry first. a tick or receive walks the table
//   ram: a read and a write-back step per live entry for aging, a read and
//   a write per entry moved on insertion; a period trim adds the divider.
//   the worst case comes with 16 peers, as the peer ram is stepped one access at a time.
// reset
//   asynchronous, active low. table empty, not started, period 100 ms.
//   table ram contents are not cleared; entries beyond the count are unused.
// stalls
//   the result sits in an output register; the next item is accepted while
//   it waits, and its own result waits in the sequencer until the register
//   frees up.
module tdma_slot_scheduler import tss_pkg::*; #(
  parameter int unsigned MAX_PEERS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tss_in_if.sink      in_ch,
  tss_out_if.source   out_ch,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  localparam int unsigned IW  = $clog2(MAX_PEERS);
  localparam int unsigned CW  = $clog2(MAX_PEERS + 1);
  localparam int unsigned DSW = CW + 2;   // enough for exact compare of distance
  localparam int unsigned QW  = 17;       // non-negative trimmed period

  // configuration
  logic [31:0] my_addr_q;
  logic [15:0] init_period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      my_addr_q     <= '0;
      init_period_q <= PERIOD_RESET;
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_idx_i))
        CFG_MY_ADDR:     my_addr_q <= cfg_data_i;
        CFG_INIT_PERIOD: init_period_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  top_state_e state_q, state_d;
  op_e         op_q, op_d;
  logic [31:0] now_q, now_d, next_q, next_d;
  logic [15:0] period_q, period_d;
  logic        started_q, started_d;
  logic        tx_q, tx_d, drop_q, drop_d;
  logic [3:0]  dist_q, dist_d;

  // output register
  logic        out_valid_q, out_valid_d;
  logic        o_tx_q, o_drop_q;
  logic [3:0]  o_slot_q, o_dist_q;
  logic [4:0]  o_count_q;
  logic [15:0] o_period_q;
  logic [31:0] o_next_q;
  logic        load_out;

  // table and divider
  tss_tbl_req_t  tbl_req;
  tss_tbl_rsp_t  tbl_rsp;
  logic [CW-1:0] live;
  logic [IW-1:0] own;
  logic          div_start, div_done;
  logic [QW-1:0] quo;
  logic [QW-1:0] quo_num;

  tss_table #(.MAX_PEERS(MAX_PEERS)) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (tbl_req),
    .rsp_o  (tbl_rsp),
    .live_o (live),
    .own_o  (own)
  );

  tss_div #(.NW(QW), .DW(CW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (quo_num),
    .divisor_i  (live),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // due test, wrap aware: now strictly later than next transmit time
  logic [31:0] due_diff;
  logic        due;
  assign due_diff = in_ch.now_ms - next_q;
  assign due      = (due_diff != 32'd0) && !due_diff[31];

  // cyclic distance from own slot to the sender
  logic [DSW-1:0] d_slot, d_own, d_live, cyc_dist;
  logic           last_before;
  assign d_slot      = DSW'(tbl_rsp.slot);
  assign d_own       = DSW'(own);
  assign d_live      = DSW'(live);
  assign cyc_dist    = (d_own > d_slot) ? d_slot + d_live - d_own : d_slot - d_own;
  assign last_before = cyc_dist == (d_live - 1'b1);

  // period trim: ratio of measured interval to period against 1.1
  logic [31:0]        interval;
  logic [35:0]        iv10, per11;
  logic signed [17:0] p_trim;
  logic [15:0]        p_sat;
  assign interval = now_q - tbl_rsp.prev_seen;
  assign iv10     = {1'b0, interval, 3'b0} + {3'b0, interval, 1'b0};
  assign per11    = 36'({period_q, 3'b0}) + 36'({period_q, 1'b0}) + 36'(period_q);
  assign p_trim   = $signed({2'b0, period_q}) + ((iv10 < per11) ? -18'sd2 : 18'sd2);
  assign quo_num  = p_trim[17] ? '0 : p_trim[QW-1:0];
  always_comb begin
    if (p_trim < $signed({2'b0, PERIOD_MIN})) begin
      p_sat = PERIOD_MIN;
    end else if (p_trim > $signed({2'b0, PERIOD_MAX})) begin
      p_sat = PERIOD_MAX;
    end else begin
      p_sat = p_trim[15:0];
    end
  end

  assign in_ch.ready = state_q == S_IDLE;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    now_d       = now_q;
    next_d      = next_q;
    period_d    = period_q;
    started_d   = started_q;
    tx_d        = tx_q;
    drop_d      = drop_q;
    dist_d      = dist_q;
    tbl_req     = '0;
    div_start   = 1'b0;
    load_out    = 1'b0;
    out_valid_d = out_valid_q && !out_ch.ready;
    tbl_req.now     = in_ch.now_ms;
    tbl_req.my_addr = my_addr_q;
    tbl_req.limit   = {period_q, 1'b0};
    tbl_req.who     = my_addr_q;
    case (state_q)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_d    = op_e'(in_ch.operation);
          now_d   = in_ch.now_ms;
          tx_d    = 1'b0;
          drop_d  = 1'b0;
          dist_d  = '0;
          state_d = S_PUT;
          case (op_e'(in_ch.operation))
            OP_START: begin
              tbl_req.start = 1'b1;
              period_d      = init_period_q;
              next_d        = in_ch.now_ms;
              started_d     = 1'b1;
              state_d       = S_TBL;
            end
            OP_TICK: begin
              if (started_q && due) begin
                tbl_req.update = 1'b1;
                tx_d           = 1'b1;
                next_d         = next_q + 32'(period_q);
                state_d        = S_TBL;
              end
            end
            OP_RX: begin
              if (started_q) begin
                tbl_req.update = 1'b1;
                tbl_req.who    = in_ch.source_address;
                state_d        = S_TBL;
              end
            end
            default: ;
          endcase
        end
      end
      S_TBL: begin
        if (tbl_rsp.done) begin
          drop_d  = tbl_rsp.dropped;
          state_d = S_PUT;
          if (op_q == OP_RX && !tbl_rsp.dropped) begin
            dist_d = cyc_dist[3:0];
            if (last_before) begin
              period_d  = p_sat;
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          // next slot: trimmed period spread over the live peers
          next_d  = now_q + 32'(quo);
          state_d = S_PUT;
        end
      end
      S_PUT: begin
        if (!out_valid_q || out_ch.ready) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      started_q   <= 1'b0;
      period_q    <= PERIOD_RESET;
      next_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      started_q   <= started_d;
      period_q    <= period_d;
      next_q      <= next_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    now_q  <= now_d;
    tx_q   <= tx_d;
    drop_q <= drop_d;
    dist_q <= dist_d;
    if (load_out) begin
      o_tx_q     <= tx_q;
      o_slot_q   <= 4'(own);
      o_count_q  <= 5'(live);
      o_dist_q   <= dist_q;
      o_period_q <= period_q;
      o_next_q   <= next_q;
      o_drop_q   <= drop_q;
    end
  end

  assign out_ch.valid              = out_valid_q;
  assign out_ch.transmit           = o_tx_q;
  assign out_ch.my_slot            = o_slot_q;
  assign out_ch.peer_count         = o_count_q;
  assign out_ch.peer_distance      = o_dist_q;
  assign out_ch.slot_period        = o_period_q;
  assign out_ch.next_transmit_time = o_next_q;
  assign out_ch.sender_dropped     = o_drop_q;

  // table answers only while the sequencer waits for it
  a_tbl_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_rsp.done |-> state_q == S_TBL)
    else $error("table done outside wait state");

  // divider finishes only during a period trim
  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider done outside wait state");

  // peer count stays within the table
  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live <= CW'(MAX_PEERS))
    else $error("peer count beyond table size");

  // a dropped sender never trims the period
  a_drop_no_trim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TBL && tbl_rsp.done && tbl_rsp.dropped) |=> state_q == S_PUT)
    else $error("trim after dropped sender");
endmodule

/* test/tdma_slot_scheduler_tb.sv */
// tdma_slot_scheduler_tb: checks the tdma slot scheduler against a behavioral peer table
// depends on tss_pkg, tss_in_if, tss_out_if and the tdma_slot_scheduler rtl
`timescale 1ns / 100ps

module tdma_slot_scheduler_tb import tss_pkg::*;;

  localparam int unsigned NPEER = 16;

  typedef struct packed {
    logic        transmit;
    logic [3:0]  my_slot;
    logic [4:0]  peer_count;
    logic [3:0]  peer_distance;
    logic [15:0] slot_period;
    logic [31:0] next_transmit_time;
    logic        sender_dropped;
  } sched_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [31:0] cfg_data_i = '0;

  tss_in_if in_ch ();
  tss_out_if out_ch ();

  tdma_slot_scheduler uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  // predictor state: shadow of the peer table and timing registers
  logic [31:0] sh_addr [NPEER];
  logic [31:0] sh_seen [NPEER];
  int unsigned sh_count, sh_own, sh_period, sh_init_period;
  logic [31:0] sh_next, sh_my_addr;
  bit sh_started;

  sched_res_t pending_q[$];
  int unsigned mismatches = 0;
  bit idle_on = 1'b1;
  logic [31:0] clock_ms = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("FAIL");
    $finish;
  end

  // age the table, refresh or insert who, relocate own slot; returns 1 when table full
  function automatic bit age_and_place(input logic [31:0] now, input logic [31:0] who,
                                       output int unsigned slot, output logic [31:0] prev);
    int unsigned k, pos;
    bit found;
    logic [31:0] lim;
    k = 0;
    found = 0;
    lim = 2 * sh_period;
    slot = 0;
    prev = 0;
    for (int i = 0; i < sh_count; i++) begin
      if (now - sh_seen[i] <= lim) begin
        sh_addr[k] = sh_addr[i];
        sh_seen[k] = sh_seen[i];
        k++;
      end
    end
    sh_count = k;
    for (int i = 0; i < sh_count; i++) begin
      if (!found && sh_addr[i] == who) begin
        prev = sh_seen[i];
        sh_seen[i] = now;
        slot = i;
        found = 1;
      end
    end
    if (!found) begin
      if (sh_count >= NPEER) return 1'b1;
      pos = sh_count;
      for (int i = sh_count - 1; i >= 0; i--) if (sh_addr[i] > who) pos = i;
      for (int i = sh_count; i > pos; i--) begin
        sh_addr[i] = sh_addr[i-1];
        sh_seen[i] = sh_seen[i-1];
      end
      sh_addr[pos] = who;
      sh_seen[pos] = now;
      sh_count++;
      prev = now;
      slot = pos;
    end
    for (int i = sh_count - 1; i >= 0; i--) if (sh_addr[i] == sh_my_addr) sh_own = i;
    return 1'b0;
  endfunction

  function automatic sched_res_t predict_schedule(input logic [1:0] op, input logic [31:0] now,
                                                  input logic [31:0] src);
    sched_res_t r;
    int unsigned slot, cdist;
    logic [31:0] prev, diff, interval;
    int p;
    bit drop;
    r = '0;
    cdist = 0;
    drop = 0;
    if (op == OP_START) begin
      sh_count = 1;
      sh_addr[0] = sh_my_addr;
      sh_seen[0] = now;
      sh_own = 0;
      sh_period = sh_init_period;
      sh_next = now;
      sh_started = 1;
    end else if (op == OP_TICK && sh_started) begin
      diff = now - sh_next;
      if (diff != 0 && !diff[31]) begin
        drop = age_and_place(now, sh_my_addr, slot, prev);
        sh_next = sh_next + sh_period;
        r.transmit = 1'b1;
      end
    end else if (op == OP_RX && sh_started) begin
      drop = age_and_place(now, src, slot, prev);
      if (!drop) begin
        interval = now - prev;
        cdist = (sh_own > slot) ? slot + sh_count - sh_own : slot - sh_own;
        if (cdist == sh_count - 1) begin
          p = sh_period;
          if (64'(interval) * 10 < 64'(sh_period) * 11) p -= 2;
          else p += 2;
          sh_next = now + (p > 0 ? p : 0) / sh_count;
          if (p < 5) p = 5;
          if (p > 1000) p = 1000;
          sh_period = p;
        end
      end
    end
    r.my_slot = sh_own[3:0];
    r.peer_count = sh_count[4:0];
    r.peer_distance = cdist[3:0];
    r.slot_period = sh_period[15:0];
    r.next_transmit_time = sh_next;
    r.sender_dropped = drop;
    return r;
  endfunction

  // append one expected result at the tail of the queue
  function automatic void queue_expected(input sched_res_t r);
    pending_q = {pending_q, r};
  endfunction

  // result side: random ready bursts, compare with oldest expectation
  initial begin
    sched_res_t got, want;
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.transmit, out_ch.my_slot, out_ch.peer_count, out_ch.peer_distance,
                out_ch.slot_period, out_ch.next_transmit_time, out_ch.sender_dropped};
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          want = pending_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: exp tx %b slot %0d cnt %0d dist %0d per %0d nxt %h drp %b",
                       want.transmit, want.my_slot, want.peer_count, want.peer_distance,
                       want.slot_period, want.next_transmit_time, want.sender_dropped);
              $display("          got tx %b slot %0d cnt %0d dist %0d per %0d nxt %h drp %b",
                       got.transmit, got.my_slot, got.peer_count, got.peer_distance,
                       got.slot_period, got.next_transmit_time, got.sender_dropped);
            end
          end
        end
      end
      if (idle_on && $urandom_range(0, 9) == 0) begin
        out_ch.ready <= 1'b0;
        gap = $urandom_range(1, 15);
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // send one item; the prediction is made when it is accepted
  task automatic send_item(input logic [1:0] op, input logic [31:0] now, input logic [31:0] src);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.now_ms <= now;
    in_ch.source_address <= src;
    do @(posedge clk_i); while (!in_ch.ready);
    queue_expected(predict_schedule(op, now, src));
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_e idx, input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_MY_ADDR) sh_my_addr = val;
    else sh_init_period = val[15:0];
    @(posedge clk_i);
  endtask

  // peer pool near own address, drawn from a small set so peers recur
  logic [31:0] peer_pool [12];

  task automatic fill_pool();
    for (int i = 0; i < 12; i++) peer_pool[i] = sh_my_addr + $urandom_range(0, 40) - 20;
  endtask

  // directed: ignored ops before start, extremes, full table, stale own entry
  task automatic test_directed();
    send_item(OP_TICK, 32'd5, 32'd0);
    send_item(OP_RX, 32'd6, 32'd9);
    send_item(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain_results();
    write_reg(CFG_MY_ADDR, 32'hFFFF_FFFF);
    write_reg(CFG_INIT_PERIOD, 16'd1);
    send_item(OP_START, 32'hFFFF_FFF0, 32'd0);
    send_item(OP_TICK, 32'hFFFF_FFF0, 32'd0);
    send_item(OP_TICK, 32'h0000_0002, 32'd0);
    send_item(OP_RX, 32'h0000_0003, 32'd0);
    drain_results();
    write_reg(CFG_MY_ADDR, 32'h8000_0000);
    write_reg(CFG_INIT_PERIOD, 16'hFFFF);
    send_item(OP_START, 32'd1000, 32'd0);
    for (int i = 0; i < 17; i++) send_item(OP_RX, 32'd1001 + i, 32'h7FFF_FFF8 + 32'(i));
    send_item(OP_RX, 32'd1100, 32'hFFFF_FFFF);
    send_item(2'd3, 32'd1101, 32'd0);
    send_item(OP_TICK, 32'd1200, 32'd0);
    drain_results();
  endtask

  // random: well-formed sessions with recurring peers, plus some noise
  task automatic test_random(input int n);
    logic [1:0] op;
    logic [31:0] src;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      clock_ms = clock_ms + $urandom_range(0, 3) * (sh_period / 4 + 1);
      if (r < 3) op = OP_START;
      else if (r < 35) op = OP_TICK;
      else if (r < 97) op = OP_RX;
      else op = 2'd3;
      src = ($urandom_range(0, 9) == 0) ? $urandom() : peer_pool[$urandom_range(0, 11)];
      if ($urandom_range(0, 49) == 0) clock_ms = $urandom();
      send_item(op, clock_ms, src);
    end
  endtask

  task automatic test_settings();
    logic [31:0] addrs [4];
    logic [15:0] pers [4];
    addrs = '{32'd0, 32'd20, 32'h8000_0000, 32'hFFFF_FFF0};
    pers = '{16'd5, 16'd100, 16'd1000, 16'd40};
    for (int s = 0; s < 4; s++) begin
      write_reg(CFG_MY_ADDR, addrs[s]);
      write_reg(CFG_INIT_PERIOD, pers[s]);
      fill_pool();
      send_item(OP_START, clock_ms, 32'd0);
      test_random(380);
      drain_results();
    end
  endtask

  initial begin
    sh_my_addr = 0;
    sh_init_period = PERIOD_RESET;
    sh_period = PERIOD_RESET;
    sh_count = 0;
    sh_own = 0;
    sh_next = 0;
    sh_started = 0;
    in_ch.valid <= 1'b0;
    in_ch.operation <= OP_TICK;
    in_ch.now_ms <= '0;
    in_ch.source_address <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_settings();
    // final stretch without idling
    idle_on = 1'b0;
    fill_pool();
    test_random(380);
    drain_results();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
